[rtl/telnet_slc_negotiator_core_macros.svh]
// Assertion macros used by the checker of this block.
`ifndef TELNET_SLC_NEGOTIATOR_CORE_MACROS_SVH
`define TELNET_SLC_NEGOTIATOR_CORE_MACROS_SVH

// Plain property, gated off while reset is active.
`define TSN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that is also checked while reset is active.
`define TSN_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/tsn_pkg.sv]
package tsn_pkg;

  // Telnet command bytes
  localparam logic [7:0] CODE_IAC      = 8'd255;
  localparam logic [7:0] CODE_SB       = 8'd250;
  localparam logic [7:0] CODE_SE       = 8'd240;
  localparam logic [7:0] CODE_LINEMODE = 8'd34;
  localparam logic [7:0] CODE_SLC      = 8'd3;

  // SLC levels
  localparam logic [1:0] LVL_NOSUPPORT = 2'd0;
  localparam logic [1:0] LVL_VALUE     = 2'd2;
  localparam logic [1:0] LVL_DEFAULT   = 2'd3;

  // modifier byte bits
  localparam int MOD_FLUSHOUT_BIT = 5;
  localparam int MOD_FLUSHIN_BIT  = 6;
  localparam int MOD_ACK_BIT      = 7;

  // reply byte selects
  localparam logic [2:0] SEL_IAC = 3'd0;
  localparam logic [2:0] SEL_SB  = 3'd1;
  localparam logic [2:0] SEL_LM  = 3'd2;
  localparam logic [2:0] SEL_SLC = 3'd3;
  localparam logic [2:0] SEL_FN  = 3'd4;
  localparam logic [2:0] SEL_MOD = 3'd5;
  localparam logic [2:0] SEL_VAL = 3'd6;
  localparam logic [2:0] SEL_SE  = 3'd7;

  typedef struct packed {
    logic       accept;
    logic       eval;
    logic       load;
    logic [2:0] sel;
    logic       last;
  } tsn_cmd_t;

  typedef struct packed {
    logic send;
    logic need_hdr;
    logic dbl;
    logic close;
    logic out_free;
  } tsn_stat_t;

  // build-time default character per function code, 255 = unsupported
  function automatic logic [7:0] default_char(input logic [7:0] code);
    logic [7:0] ch;
    case (code)
      8'd3:    ch = 8'd3;
      8'd4:    ch = 8'd15;
      8'd5:    ch = 8'd0;
      8'd6:    ch = 8'd0;
      8'd7:    ch = 8'd28;
      8'd8:    ch = 8'd4;
      8'd9:    ch = 8'd26;
      8'd10:   ch = 8'd127;
      8'd11:   ch = 8'd21;
      8'd12:   ch = 8'd23;
      8'd13:   ch = 8'd18;
      8'd14:   ch = 8'd22;
      8'd15:   ch = 8'd17;
      8'd16:   ch = 8'd19;
      default: ch = CODE_IAC;
    endcase
    return ch;
  endfunction

  // stored level: {flushin, flushout, level}
  function automatic logic [3:0] default_level(input logic [7:0] ch);
    return (ch == CODE_IAC) ? {2'b00, LVL_NOSUPPORT} : {2'b00, LVL_VALUE};
  endfunction

  function automatic logic [7:0] level_to_mod(input logic [3:0] lv);
    return {1'b0, lv[3], lv[2], 3'b000, lv[1:0]};
  endfunction

  function automatic logic [3:0] mod_to_level(input logic [7:0] m);
    return {m[MOD_FLUSHIN_BIT], m[MOD_FLUSHOUT_BIT], m[1:0]};
  endfunction

endpackage

[rtl/tsn_in_if.sv]
interface tsn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] function_code;
  logic [7:0] modifier;
  logic [7:0] char_value;
  logic       last_triplet;

  modport source (output valid, function_code, modifier, char_value, last_triplet,
                  input ready);
  modport sink (input valid, function_code, modifier, char_value, last_triplet,
                output ready);
endinterface

[rtl/tsn_out_if.sv]
interface tsn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       reply_last;

  modport source (output valid, reply_byte, reply_last, input ready);
  modport sink (input valid, reply_byte, reply_last, output ready);
endinterface

[rtl/telnet_slc_negotiator_core.sv]
// Telnet LINEMODE SLC negotiator.
// in_ch carries one SLC request (function code, modifier, value, last flag);
// out_ch returns the reply one byte at a time, reply_last marking the
// final byte a request causes. A request that causes no reply gives no bytes.
// Steps: the request is captured on acceptance, evaluated in S_EVAL and its
// reply planned in S_PLAN; the byte sequencer that drives the single output
// register then loads the reply bytes the request causes (0 to 10) in order.
// Requests are taken one at a time; in_ch.ready rises again once the last
// reply byte is loaded, even while that byte still waits at the output.
// A stalled receiver holds the output register and the sequencer with it.
// Reset (rst_n low, synchronous) reloads the SLC table with the build-time
// default characters and levels, clears the header flag and empties the
// output register.
module telnet_slc_negotiator_core #(
  parameter int MAX_FUNCTION = 18
) (
  input  logic      clk,
  input  logic      rst_n,
  tsn_in_if.sink    in_ch,
  tsn_out_if.source out_ch
);

  tsn_pkg::tsn_cmd_t  cmd;
  tsn_pkg::tsn_stat_t stat;

  // sequencer: request capture, evaluation, reply byte order
  tsn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // SLC table, rule evaluation and output register
  tsn_datapath #(
    .MAX_FUNCTION (MAX_FUNCTION)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_function_code (in_ch.function_code),
    .in_modifier      (in_ch.modifier),
    .in_char_value    (in_ch.char_value),
    .in_last_triplet  (in_ch.last_triplet),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_reply_byte   (out_ch.reply_byte),
    .out_reply_last   (out_ch.reply_last)
  );

endmodule

[rtl/tsn_datapath.sv]
module tsn_datapath #(
  parameter int MAX_FUNCTION = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_function_code,
  input  logic [7:0]         in_modifier,
  input  logic [7:0]         in_char_value,
  input  logic               in_last_triplet,
  input  tsn_pkg::tsn_cmd_t  cmd,
  output tsn_pkg::tsn_stat_t stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         out_reply_byte,
  output logic               out_reply_last
);

  localparam int DEPTH = MAX_FUNCTION + 1;
  localparam int IDX_W = $clog2(DEPTH);

  logic [7:0] char_r [DEPTH];
  logic [3:0] lvl_r  [DEPTH];
  logic       hdr_r, hdr_nxt;

  logic [7:0] fn_r, mod_r, val_r;
  logic       last_r;

  logic       send_r, need_hdr_r, close_r;
  logic [7:0] rep_mod_r, rep_val_r;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic [IDX_W-1:0] idx;
  logic             in_range, differ, acked;
  logic [7:0]       cur_ch, req_mod, dflt_ch;
  logic [3:0]       cur_lv, dflt_lv;
  logic [1:0]       req_lv;
  logic             wr, send, ack;
  logic [7:0]       new_ch;
  logic [3:0]       new_lv;
  logic [7:0]       sel_byte;

  assign idx      = fn_r[IDX_W-1:0];
  assign in_range = (fn_r <= 8'(MAX_FUNCTION));
  assign cur_ch   = char_r[idx];
  assign cur_lv   = lvl_r[idx];
  assign req_mod  = mod_r & 8'h63;
  assign req_lv   = mod_r[1:0];
  assign acked    = mod_r[tsn_pkg::MOD_ACK_BIT];
  assign differ   = (cur_ch != val_r) || (tsn_pkg::level_to_mod(cur_lv) != req_mod);
  assign dflt_ch  = tsn_pkg::default_char(fn_r);
  assign dflt_lv  = tsn_pkg::default_level(dflt_ch);

  // negotiation rules
  always_comb begin
    wr     = 1'b0;
    send   = 1'b0;
    ack    = 1'b0;
    new_ch = cur_ch;
    new_lv = cur_lv;
    if (in_range && differ) begin
      if (req_lv == tsn_pkg::LVL_NOSUPPORT) begin
        if (cur_lv[1:0] != tsn_pkg::LVL_NOSUPPORT) begin
          wr     = 1'b1;
          new_ch = tsn_pkg::CODE_IAC;
          new_lv = {2'b00, tsn_pkg::LVL_NOSUPPORT};
          send   = !acked;
          ack    = 1'b1;
        end
      end else if (req_lv == tsn_pkg::LVL_DEFAULT) begin
        wr     = 1'b1;
        new_ch = dflt_ch;
        new_lv = dflt_lv;
        send   = 1'b1;
      end else if (req_lv > cur_lv[1:0]) begin
        // refused: answer with the current setting
        send = 1'b1;
      end else begin
        wr     = 1'b1;
        new_ch = val_r;
        new_lv = tsn_pkg::mod_to_level(req_mod);
        send   = !acked;
        ack    = 1'b1;
      end
    end
  end

  assign hdr_nxt = last_r ? 1'b0 : (hdr_r | send);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        char_r[i] <= tsn_pkg::default_char(8'(i));
        lvl_r[i]  <= tsn_pkg::default_level(tsn_pkg::default_char(8'(i)));
      end
      hdr_r <= 1'b0;
    end else if (cmd.eval) begin
      if (wr) begin
        char_r[idx] <= new_ch;
        lvl_r[idx]  <= new_lv;
      end
      hdr_r <= hdr_nxt;
    end
  end

  // captured request and reply plan
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      fn_r   <= in_function_code;
      mod_r  <= in_modifier;
      val_r  <= in_char_value;
      last_r <= in_last_triplet;
    end
    if (cmd.eval) begin
      send_r     <= send;
      need_hdr_r <= send && !hdr_r;
      close_r    <= last_r && (hdr_r || send);
      rep_mod_r  <= tsn_pkg::level_to_mod(new_lv) | {ack, 7'd0};
      rep_val_r  <= new_ch;
    end
  end

  always_comb begin
    case (cmd.sel)
      tsn_pkg::SEL_IAC: sel_byte = tsn_pkg::CODE_IAC;
      tsn_pkg::SEL_SB:  sel_byte = tsn_pkg::CODE_SB;
      tsn_pkg::SEL_LM:  sel_byte = tsn_pkg::CODE_LINEMODE;
      tsn_pkg::SEL_SLC: sel_byte = tsn_pkg::CODE_SLC;
      tsn_pkg::SEL_FN:  sel_byte = fn_r;
      tsn_pkg::SEL_MOD: sel_byte = rep_mod_r;
      tsn_pkg::SEL_VAL: sel_byte = rep_val_r;
      default:          sel_byte = tsn_pkg::CODE_SE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_byte_r <= sel_byte;
      out_last_r <= cmd.last;
    end
  end

  assign stat.send     = send_r;
  assign stat.need_hdr = need_hdr_r;
  assign stat.dbl      = (rep_val_r == tsn_pkg::CODE_IAC);
  assign stat.close    = close_r;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_reply_byte = out_byte_r;
  assign out_reply_last = out_last_r;

endmodule

[rtl/tsn_ctrl.sv]
module tsn_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tsn_pkg::tsn_stat_t stat,
  output tsn_pkg::tsn_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EVAL = 4'd1;
  localparam logic [3:0] S_PLAN = 4'd2;
  localparam logic [3:0] S_H0   = 4'd3;
  localparam logic [3:0] S_H1   = 4'd4;
  localparam logic [3:0] S_H2   = 4'd5;
  localparam logic [3:0] S_H3   = 4'd6;
  localparam logic [3:0] S_FN   = 4'd7;
  localparam logic [3:0] S_MOD  = 4'd8;
  localparam logic [3:0] S_VAL  = 4'd9;
  localparam logic [3:0] S_DBL  = 4'd10;
  localparam logic [3:0] S_IAC  = 4'd11;
  localparam logic [3:0] S_SE   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       emit;
  logic [2:0] sel;
  logic       rep_last;

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.accept = in_ready && in_valid;
  assign cmd.eval   = (state_r == S_EVAL);
  assign cmd.sel    = sel;
  assign cmd.last   = rep_last;

  always_comb begin
    state_nxt = state_r;
    emit      = 1'b0;
    sel       = tsn_pkg::SEL_IAC;
    rep_last  = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EVAL;
      S_EVAL: state_nxt = S_PLAN;
      S_PLAN: begin
        if (stat.need_hdr)   state_nxt = S_H0;
        else if (stat.send)  state_nxt = S_FN;
        else if (stat.close) state_nxt = S_IAC;
        else                 state_nxt = S_IDLE;
      end
      S_H0: begin
        emit = 1'b1;
        sel = tsn_pkg::SEL_IAC;
        if (stat.out_free) state_nxt = S_H1;
      end
      S_H1: begin
        emit = 1'b1;
        sel = tsn_pkg::SEL_SB;
        if (stat.out_free) state_nxt = S_H2;
      end
      S_H2: begin
        emit = 1'b1;
        sel = tsn_pkg::SEL_LM;
        if (stat.out_free) state_nxt = S_H3;
      end
      S_H3: begin
        emit = 1'b1;
        sel = tsn_pkg::SEL_SLC;
        if (stat.out_free) state_nxt = S_FN;
      end
      S_FN: begin
        emit = 1'b1;
        sel = tsn_pkg::SEL_FN;
        if (stat.out_free) state_nxt = S_MOD;
      end
      S_MOD: begin
        emit = 1'b1;
        sel = tsn_pkg::SEL_MOD;
        if (stat.out_free) state_nxt = S_VAL;
      end
      S_VAL: begin
        emit = 1'b1;
        sel = tsn_pkg::SEL_VAL;
        rep_last = !stat.dbl && !stat.close;
        if (stat.out_free) begin
          if (stat.dbl)        state_nxt = S_DBL;
          else if (stat.close) state_nxt = S_IAC;
          else                 state_nxt = S_IDLE;
        end
      end
      S_DBL: begin
        emit = 1'b1;
        sel = tsn_pkg::SEL_IAC;
        rep_last = !stat.close;
        if (stat.out_free) state_nxt = stat.close ? S_IAC : S_IDLE;
      end
      S_IAC: begin
        emit = 1'b1;
        sel = tsn_pkg::SEL_IAC;
        if (stat.out_free) state_nxt = S_SE;
      end
      S_SE: begin
        emit = 1'b1;
        sel = tsn_pkg::SEL_SE;
        rep_last = 1'b1;
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cmd.load = emit && stat.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/tsn_checker.sv]
`include "telnet_slc_negotiator_core_macros.svh"

module tsn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_reply_byte,
  input logic       out_reply_last
);

  // a stalled reply byte holds
  `TSN_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_reply_byte) && $stable(out_reply_last), "reply byte changed while stalled")

  // one request at a time: ready drops after a request is taken
  `TSN_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "request taken while busy")

  // reset leaves the block ready and the output empty
  `TSN_ASSERT_RST(a_reset_state, !rst_n |=> in_ready && !out_valid, "bad state after reset")

endmodule

bind telnet_slc_negotiator_core tsn_checker u_tsn_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_reply_byte (out_ch.reply_byte),
  .out_reply_last (out_ch.reply_last)
);
